### sv/lfr_pkg.sv
// Package for the link frame receiver.
// Holds the byte constants, the frame phase type and the result record.
// No dependencies.
package lfr_pkg;

    localparam int ByteW = 8;

    localparam logic [ByteW-1:0] FLAG_BYTE        = 8'h7E;
    localparam logic [ByteW-1:0] CTRL_SEQ0        = 8'h00;
    localparam logic [ByteW-1:0] CTRL_SEQ1        = 8'h40;
    localparam logic [ByteW-1:0] REPLY_AFTER_SEQ0 = 8'h85;
    localparam logic [ByteW-1:0] REPLY_AFTER_SEQ1 = 8'h05;
    localparam logic [ByteW-1:0] ADDR_RESET       = 8'h03;

    typedef enum logic [4:0] {
        PH_OPEN = 5'b00001,
        PH_ADDR = 5'b00010,
        PH_CTRL = 5'b00100,
        PH_HCHK = 5'b01000,
        PH_BODY = 5'b10000
    } phase_t;

    typedef struct packed {
        logic             err_open_flag;
        logic             err_address;
        logic             err_control;
        logic             err_header_check;
    } hdr_err_t;

    typedef struct packed {
        logic             payload_valid;
        logic [ByteW-1:0] payload_byte;
        logic             frame_done;
        logic             seq_bit;
        logic [ByteW-1:0] reply_control;
        hdr_err_t         hdr_err;
        logic             err_body_check;
    } lfr_result_t;

endpackage

### sv/lfr_frame_core.sv
// Frame parser of the link frame receiver: phase tracking, header checks,
// body XOR and the one-byte payload hold. Depends on lfr_pkg.
module lfr_frame_core
    import lfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [ByteW-1:0] rx_byte,
    input  logic [ByteW-1:0] expected_address,
    output lfr_result_t      result
);

    phase_t           phase_reg, phase_next;
    logic [ByteW-1:0] saved_address_reg, saved_address_next;
    logic [ByteW-1:0] saved_control_reg, saved_control_next;
    logic [ByteW-1:0] body_xor_reg, body_xor_next;
    logic [ByteW-1:0] held_byte_reg, held_byte_next;
    logic             held_valid_reg, held_valid_next;
    hdr_err_t         err_reg, err_next;
    logic             seq;

    assign seq = (saved_control_reg != CTRL_SEQ0);

    always_comb
    begin
        phase_next         = phase_reg;
        saved_address_next = saved_address_reg;
        saved_control_next = saved_control_reg;
        body_xor_next      = body_xor_reg;
        held_byte_next     = held_byte_reg;
        held_valid_next    = held_valid_reg;
        err_next           = err_reg;
        result             = '0;
        unique case (phase_reg)
            PH_OPEN:
            begin
                err_next               = '0;
                err_next.err_open_flag = (rx_byte != FLAG_BYTE);
                body_xor_next          = '0;
                held_byte_next         = '0;
                held_valid_next        = 1'b0;
                phase_next             = PH_ADDR;
            end
            PH_ADDR:
            begin
                saved_address_next = rx_byte;
                if (rx_byte != expected_address)
                begin
                    err_next.err_address = 1'b1;
                end
                phase_next = PH_CTRL;
            end
            PH_CTRL:
            begin
                saved_control_next = rx_byte;
                if ((rx_byte != CTRL_SEQ0) && (rx_byte != CTRL_SEQ1))
                begin
                    err_next.err_control = 1'b1;
                end
                phase_next = PH_HCHK;
            end
            PH_HCHK:
            begin
                if (rx_byte != (saved_address_reg ^ saved_control_reg))
                begin
                    err_next.err_header_check = 1'b1;
                end
                phase_next = PH_BODY;
            end
            PH_BODY:
            begin
                if (rx_byte == FLAG_BYTE)
                begin
                    result.frame_done     = 1'b1;
                    result.seq_bit        = seq;
                    result.reply_control  = seq ? REPLY_AFTER_SEQ1 : REPLY_AFTER_SEQ0;
                    result.hdr_err        = err_reg;
                    result.err_body_check = !held_valid_reg
                                            || (body_xor_reg != held_byte_reg);
                    held_valid_next       = 1'b0;
                    held_byte_next        = '0;
                    body_xor_next         = '0;
                    phase_next            = PH_OPEN;
                end
                else
                begin
                    if (held_valid_reg)
                    begin
                        result.payload_valid = 1'b1;
                        result.payload_byte  = held_byte_reg;
                        body_xor_next        = body_xor_reg ^ held_byte_reg;
                    end
                    held_byte_next  = rx_byte;
                    held_valid_next = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_OPEN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_OPEN;
            saved_address_reg <= '0;
            saved_control_reg <= '0;
            body_xor_reg      <= '0;
            held_byte_reg     <= '0;
            held_valid_reg    <= 1'b0;
            err_reg           <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            saved_address_reg <= saved_address_next;
            saved_control_reg <= saved_control_next;
            body_xor_reg      <= body_xor_next;
            held_byte_reg     <= held_byte_next;
            held_valid_reg    <= held_valid_next;
            err_reg           <= err_next;
        end
    end

endmodule

### sv/link_frame_receiver_top.sv
// Top level of the link frame receiver: input register, frame parser and
// result register with the valid/stall handshakes. Depends on lfr_pkg and
// lfr_frame_core.
//
// Bytes enter on the input channel (in_valid, in_stall, rx_byte), one per
// transfer. Every accepted byte yields exactly one result transfer on the
// output channel (out_valid, out_stall and the result fields). A result
// carries either a payload byte, which is the body byte received one byte
// earlier, or the frame report when the closing flag arrives, or nothing.
// A byte passes the input register and then the result register, and the
// block sustains one byte per cycle while the receiver does not stall; the
// per-byte parse sits between the input register and the result register.
// The expected address is written with cfg_we and cfg_wdata; the user must
// do so only while idle, the block does not enforce it. Reset empties both
// registers, returns the parser to the opening position and loads the
// expected address with 0x03. On a receiver stall the result register holds
// its transfer; an empty input register takes a byte, then in_stall rises.
module link_frame_receiver_top
    import lfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [ByteW-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [ByteW-1:0] rx_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             payload_valid,
    output logic [ByteW-1:0] payload_byte,
    output logic             frame_done,
    output logic             seq_bit,
    output logic [ByteW-1:0] reply_control,
    output logic             err_open_flag,
    output logic             err_address,
    output logic             err_control,
    output logic             err_header_check,
    output logic             err_body_check
);

    logic [ByteW-1:0] exp_addr_reg;
    logic             s1_valid_reg;
    logic [ByteW-1:0] s1_byte_reg;
    logic             out_valid_reg;
    lfr_result_t      result_reg;
    lfr_result_t      core_result;
    logic             res_ready;
    logic             step;
    logic             in_take;

    assign res_ready = !out_valid_reg || !out_stall;
    assign step      = s1_valid_reg && res_ready;
    assign in_stall  = s1_valid_reg && !res_ready;
    assign in_take   = in_valid && !in_stall;

    lfr_frame_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .rx_byte          (s1_byte_reg),
        .expected_address (exp_addr_reg),
        .result           (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_addr_reg  <= ADDR_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                exp_addr_reg <= cfg_wdata;
            end
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (step)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign payload_valid    = result_reg.payload_valid;
    assign payload_byte     = result_reg.payload_byte;
    assign frame_done       = result_reg.frame_done;
    assign seq_bit          = result_reg.seq_bit;
    assign reply_control    = result_reg.reply_control;
    assign err_open_flag    = result_reg.hdr_err.err_open_flag;
    assign err_address      = result_reg.hdr_err.err_address;
    assign err_control      = result_reg.hdr_err.err_control;
    assign err_header_check = result_reg.hdr_err.err_header_check;
    assign err_body_check   = result_reg.err_body_check;

    a_no_payload_with_report: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> !(payload_valid && frame_done))
        else $error("Result carries both a payload byte and a frame report.");

    a_report_fields_only_on_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_done) |->
            (!seq_bit && reply_control == '0 && !err_open_flag && !err_address
             && !err_control && !err_header_check && !err_body_check))
        else $error("Frame report fields set without a closing flag.");

    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("Input stalled while the result register could move.");

    a_step_fills_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("Parsed byte did not reach the result register.");

endmodule

### sim/link_frame_receiver_top_test.sv
// Testbench for link_frame_receiver_top: byte frames go in, every result transfer is checked
// against an in-bench frame parser, with random idling on both channels and address rewrites.
// Depends on lfr_pkg and link_frame_receiver_top.
module link_frame_receiver_top_test;
    import lfr_pkg::*;

    localparam int ITEMS       = 450;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 10;

    typedef enum int {
        FR_GOOD,
        FR_BAD_HEADER,
        FR_BAD_CHECK,
        FR_EMPTY,
        FR_NOISE
    } frame_kind_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [ByteW-1:0] cfg_wdata = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [ByteW-1:0] rx_byte = '0;
    logic             out_valid;
    logic             out_stall = 1'b1;
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    logic             frame_done;
    logic             seq_bit;
    logic [ByteW-1:0] reply_control;
    logic             err_open_flag;
    logic             err_address;
    logic             err_control;
    logic             err_header_check;
    logic             err_body_check;

    link_frame_receiver_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .payload_valid    (payload_valid),
        .payload_byte     (payload_byte),
        .frame_done       (frame_done),
        .seq_bit          (seq_bit),
        .reply_control    (reply_control),
        .err_open_flag    (err_open_flag),
        .err_address      (err_address),
        .err_control      (err_control),
        .err_header_check (err_header_check),
        .err_body_check   (err_body_check)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [ByteW-1:0] pending_bytes[$];
    logic [ByteW-1:0] frame_buf[$];
    lfr_result_t      due_results[$];

    phase_t           parse_phase = PH_OPEN;
    logic [ByteW-1:0] addr_reg = ADDR_RESET;
    logic [ByteW-1:0] saved_addr = '0;
    logic [ByteW-1:0] saved_ctrl = '0;
    logic [ByteW-1:0] body_sum = '0;
    logic [ByteW-1:0] held_byte = '0;
    logic             held_ok = 1'b0;
    hdr_err_t         hdr_flags = '0;

    logic             byte_taken = 1'b0;
    logic             res_taken = 1'b0;
    logic             no_idle = 1'b0;
    int               send_wait = 0;
    int               recv_wait = 0;
    int               cycles = 0;
    int               mismatches = 0;
    int               queued_bytes = 0;
    int               bytes_accepted = 0;
    int               frames_closed = 0;
    int               payload_seen = 0;
    int               cfg_writes = 0;
    logic [ByteW-1:0] cur_addr = ADDR_RESET;

    function automatic int pause_len();
        if (no_idle)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    task automatic parse_rx_byte(input logic [ByteW-1:0] b);
        lfr_result_t r;
        logic        seq;
        r = '0;
        case (parse_phase)
            PH_OPEN:
            begin
                hdr_flags = '0;
                hdr_flags.err_open_flag = (b != FLAG_BYTE);
                body_sum = '0;
                held_byte = '0;
                held_ok = 1'b0;
                parse_phase = PH_ADDR;
            end
            PH_ADDR:
            begin
                saved_addr = b;
                if (b != addr_reg)
                    hdr_flags.err_address = 1'b1;
                parse_phase = PH_CTRL;
            end
            PH_CTRL:
            begin
                saved_ctrl = b;
                if (b != CTRL_SEQ0 && b != CTRL_SEQ1)
                    hdr_flags.err_control = 1'b1;
                parse_phase = PH_HCHK;
            end
            PH_HCHK:
            begin
                if (b != (saved_addr ^ saved_ctrl))
                    hdr_flags.err_header_check = 1'b1;
                parse_phase = PH_BODY;
            end
            default:
            begin
                if (b == FLAG_BYTE)
                begin
                    seq = (saved_ctrl != CTRL_SEQ0);
                    r.frame_done = 1'b1;
                    r.seq_bit = seq;
                    r.reply_control = seq ? REPLY_AFTER_SEQ1 : REPLY_AFTER_SEQ0;
                    r.hdr_err = hdr_flags;
                    r.err_body_check = !held_ok || (body_sum != held_byte);
                    held_ok = 1'b0;
                    held_byte = '0;
                    body_sum = '0;
                    parse_phase = PH_OPEN;
                end
                else
                begin
                    if (held_ok)
                    begin
                        r.payload_valid = 1'b1;
                        r.payload_byte = held_byte;
                        body_sum = body_sum ^ held_byte;
                    end
                    held_byte = b;
                    held_ok = 1'b1;
                end
            end
        endcase
        due_results.push_back(r);
    endtask

    always @(posedge clk)
    begin : watch_transfers
        lfr_result_t got;
        lfr_result_t want;
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            byte_taken <= in_valid && !in_stall;
            res_taken <= out_valid && !out_stall;
            if (rst_n)
            begin
                if (cfg_we)
                    addr_reg = cfg_wdata;
                if (out_valid && !out_stall)
                begin
                    got.payload_valid = payload_valid;
                    got.payload_byte = payload_byte;
                    got.frame_done = frame_done;
                    got.seq_bit = seq_bit;
                    got.reply_control = reply_control;
                    got.hdr_err.err_open_flag = err_open_flag;
                    got.hdr_err.err_address = err_address;
                    got.hdr_err.err_control = err_control;
                    got.hdr_err.err_header_check = err_header_check;
                    got.err_body_check = err_body_check;
                    if (frame_done === 1'b1)
                        frames_closed++;
                    if (payload_valid === 1'b1)
                        payload_seen++;
                    if (due_results.size() == 0)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("cycle %0d: result transfer with nothing expected", cycles);
                    end
                    else
                    begin
                        want = due_results.pop_front();
                        if (got.payload_valid !== want.payload_valid
                            || got.payload_byte !== want.payload_byte
                            || got.frame_done !== want.frame_done
                            || got.seq_bit !== want.seq_bit
                            || got.reply_control !== want.reply_control
                            || got.hdr_err !== want.hdr_err
                            || got.err_body_check !== want.err_body_check)
                        begin
                            mismatches++;
                            if (mismatches <= MAX_REPORTS)
                                $display({"cycle %0d: expected pv=%b pb=%h done=%b seq=%b ",
                                          "reply=%h err=%b%b, got pv=%b pb=%h done=%b ",
                                          "seq=%b reply=%h err=%b%b"},
                                         cycles, want.payload_valid, want.payload_byte,
                                         want.frame_done, want.seq_bit, want.reply_control,
                                         want.hdr_err, want.err_body_check,
                                         got.payload_valid, got.payload_byte,
                                         got.frame_done, got.seq_bit, got.reply_control,
                                         got.hdr_err, got.err_body_check);
                        end
                    end
                end
                if (in_valid && !in_stall)
                begin
                    bytes_accepted++;
                    parse_rx_byte(rx_byte);
                end
            end
        end
    end

    always @(negedge clk)
    begin : drive_bytes
        logic nv;
        nv = in_valid;
        if (rst_n)
        begin
            if (in_valid && byte_taken)
                nv = 1'b0;
            if (!nv)
            begin
                if (send_wait > 0)
                    send_wait = send_wait - 1;
                else if (pending_bytes.size() > 0)
                begin
                    rx_byte <= pending_bytes.pop_front();
                    nv = 1'b1;
                    send_wait = pause_len();
                end
            end
            in_valid <= nv;
        end
    end

    always @(negedge clk)
    begin : drive_stall
        if (rst_n)
        begin
            if (res_taken)
                recv_wait = pause_len();
            if (recv_wait > 0)
            begin
                out_stall <= 1'b1;
                recv_wait = recv_wait - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic queue_byte(input logic [ByteW-1:0] b);
        pending_bytes.push_back(b);
        queued_bytes++;
    endtask

    task automatic queue_span(input int lo, input int hi);
        for (int i = lo; i < hi; i++)
            queue_byte(frame_buf[i]);
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_address(input logic [ByteW-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_addr = v;
        cfg_writes++;
    endtask

    task automatic build_frame(input logic [ByteW-1:0] addr, input frame_kind_t kind);
        logic [ByteW-1:0] ctrl;
        logic [ByteW-1:0] chk;
        logic [ByteW-1:0] d;
        logic [ByteW-1:0] e;
        logic [ByteW-1:0] body[$];
        int               len;
        int               pos;
        frame_buf.delete();
        if (kind == FR_NOISE)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                d = ($urandom_range(0, 3) == 0) ? FLAG_BYTE : ByteW'($urandom_range(0, 255));
                frame_buf.push_back(d);
            end
            return;
        end
        ctrl = $urandom_range(0, 1) ? CTRL_SEQ1 : CTRL_SEQ0;
        frame_buf.push_back(FLAG_BYTE);
        frame_buf.push_back(addr);
        frame_buf.push_back(ctrl);
        frame_buf.push_back(addr ^ ctrl);
        if (kind == FR_BAD_HEADER)
        begin
            pos = $urandom_range(0, 3);
            frame_buf[pos] = ByteW'($urandom_range(0, 255));
        end
        if (kind != FR_EMPTY)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            do
            begin
                body.delete();
                chk = '0;
                for (int i = 0; i < len; i++)
                begin
                    do
                        d = ByteW'($urandom_range(0, 255));
                    while (d == FLAG_BYTE);
                    body.push_back(d);
                    chk = chk ^ d;
                end
            end
            while (chk == FLAG_BYTE);
            if (kind == FR_BAD_CHECK)
            begin
                do
                    e = ByteW'($urandom_range(1, 255));
                while ((chk ^ e) == FLAG_BYTE);
                chk = chk ^ e;
            end
            foreach (body[i])
                frame_buf.push_back(body[i]);
            frame_buf.push_back(chk);
        end
        frame_buf.push_back(FLAG_BYTE);
    endtask

    function automatic frame_kind_t pick_kind();
        int k;
        k = $urandom_range(0, 19);
        if (k < 13)
            return FR_GOOD;
        if (k < 15)
            return FR_BAD_HEADER;
        if (k < 17)
            return FR_BAD_CHECK;
        if (k < 18)
            return FR_EMPTY;
        return FR_NOISE;
    endfunction

    initial
    begin : stimulus
        int               phase_no;
        logic [ByteW-1:0] next_addr;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        recv_wait = pause_len();

        queue_byte(FLAG_BYTE); queue_byte(ADDR_RESET); queue_byte(CTRL_SEQ0);
        queue_byte(ADDR_RESET); queue_byte(8'h00); queue_byte(8'hFF);
        queue_byte(8'hFF); queue_byte(FLAG_BYTE);

        queue_byte(FLAG_BYTE); queue_byte(ADDR_RESET); queue_byte(CTRL_SEQ1);
        queue_byte(ADDR_RESET ^ CTRL_SEQ1); queue_byte(FLAG_BYTE);

        queue_byte(8'h00); queue_byte(FLAG_BYTE); queue_byte(8'hFF);
        queue_byte(FLAG_BYTE ^ 8'hFF); queue_byte(8'h00); queue_byte(FLAG_BYTE);

        queue_byte(8'hFF); queue_byte(ADDR_RESET); queue_byte(CTRL_SEQ0);
        queue_byte(FLAG_BYTE); queue_byte(8'h55); queue_byte(FLAG_BYTE);

        phase_no = 0;
        while (queued_bytes < ITEMS)
        begin
            wait_idle();
            case (phase_no % 5)
                0: next_addr = 8'h00;
                1: next_addr = 8'hFF;
                2: next_addr = FLAG_BYTE;
                default: next_addr = ByteW'($urandom_range(0, 255));
            endcase
            write_address(next_addr);
            no_idle = (phase_no % 4 == 3);
            if (phase_no % 3 == 1)
            begin
                // The address is rewritten while the parser sits between the flag and the
                // address, and again right after the address transfer.
                build_frame(cur_addr, FR_GOOD);
                queue_span(0, 1);
                wait_idle();
                write_address(ByteW'($urandom_range(0, 255)));
                build_frame(cur_addr, FR_GOOD);
                queue_span(1, 2);
                wait_idle();
                write_address(ByteW'($urandom_range(0, 255)));
                queue_span(2, frame_buf.size());
            end
            repeat (6)
            begin
                build_frame(cur_addr, pick_kind());
                queue_span(0, frame_buf.size());
            end
            phase_no++;
        end

        wait_idle();
        repeat (6) @(posedge clk);
        $display("%0d bytes accepted, %0d frames closed, %0d payload bytes, %0d address writes",
                 bytes_accepted, frames_closed, payload_seen, cfg_writes);
        $display("%0d mismatches, %0d results still expected", mismatches, due_results.size());
        if (mismatches == 0 && due_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
